@@ sv/ssi_pkg.sv @@
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared widths, types and relation codes for the segment intersection block.
// ----------------------------------------------------------------------------
package ssi_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int SUM_BITS   = PROD_BITS + 1;
  localparam int MAG_BITS   = SUM_BITS - 1;
  localparam int NUM_BITS   = MAG_BITS + COORD_BITS;

  typedef enum logic [1:0] {
    REL_DISJOINT   = 2'd0,
    REL_CROSSING   = 2'd1,
    REL_PARALLEL   = 2'd2,
    REL_COINCIDENT = 2'd3
  } relation_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] first_start_x;
    logic signed [COORD_BITS-1:0] first_start_y;
    logic signed [COORD_BITS-1:0] first_end_x;
    logic signed [COORD_BITS-1:0] first_end_y;
    logic signed [COORD_BITS-1:0] second_start_x;
    logic signed [COORD_BITS-1:0] second_start_y;
    logic signed [COORD_BITS-1:0] second_end_x;
    logic signed [COORD_BITS-1:0] second_end_y;
  } ssi_pair_t;

  // one lane per coordinate: 0 is x, 1 is y
  typedef struct packed {
    logic [MAG_BITS-1:0]             den;
    logic [1:0][NUM_BITS-1:0]        num;
    logic [1:0]                      neg;
    logic [1:0][COORD_BITS-1:0]      base;
    logic                            crosses;
    relation_t                       relation;
  } ssi_div_t;

endpackage

@@ sv/ssi_in_if.sv @@
// ----------------------------------------------------------------------------
// ssi_in_if
// Input channel: one pair of segments per transfer.
// ----------------------------------------------------------------------------
interface ssi_in_if;
  import ssi_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] first_start_x;
  logic signed [COORD_BITS-1:0] first_start_y;
  logic signed [COORD_BITS-1:0] first_end_x;
  logic signed [COORD_BITS-1:0] first_end_y;
  logic signed [COORD_BITS-1:0] second_start_x;
  logic signed [COORD_BITS-1:0] second_start_y;
  logic signed [COORD_BITS-1:0] second_end_x;
  logic signed [COORD_BITS-1:0] second_end_y;

  modport source (
    output valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    input  ready
  );
  modport sink (
    input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
           second_start_x, second_start_y, second_end_x, second_end_y,
    output ready
  );
endinterface

@@ sv/ssi_out_if.sv @@
// ----------------------------------------------------------------------------
// ssi_out_if
// Result channel: classification and intersection point per transfer.
// ----------------------------------------------------------------------------
interface ssi_out_if;
  import ssi_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         crosses;
  logic [1:0]                   relation;
  logic signed [COORD_BITS-1:0] cross_x;
  logic signed [COORD_BITS-1:0] cross_y;

  modport source (output valid, crosses, relation, cross_x, cross_y, input ready);
  modport sink   (input valid, crosses, relation, cross_x, cross_y, output ready);
endinterface

@@ sv/ssi_front.sv @@
// ----------------------------------------------------------------------------
// ssi_front
// Differences, cross products, numerators, classification and the scaled
// numerators for the point, in five register stages.
// ----------------------------------------------------------------------------
module ssi_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  ssi_pkg::ssi_pair_t pair,
  output logic              out_valid,
  output ssi_pkg::ssi_div_t item
);
  import ssi_pkg::*;

  logic [4:0] vld;

  // stage 1
  logic signed [DIFF_BITS-1:0]  dx1, dy1, dx2, dy2, ox, oy;
  logic signed [COORD_BITS-1:0] sx1, sy1;
  // stage 2
  logic signed [PROD_BITS-1:0]  pd1, pd2, pa1, pa2, pb1, pb2;
  logic signed [DIFF_BITS-1:0]  dx1_2, dy1_2;
  logic signed [COORD_BITS-1:0] sx1_2, sy1_2;
  // stage 3
  logic signed [SUM_BITS-1:0]   d, na, nb;
  logic signed [DIFF_BITS-1:0]  dx1_3, dy1_3;
  logic signed [COORD_BITS-1:0] sx1_3, sy1_3;
  // stage 4
  logic [MAG_BITS-1:0]          dmag, namag;
  logic [1:0][COORD_BITS-1:0]   amag, base4;
  logic [1:0]                   neg4;
  logic                         cross4;
  relation_t                    rel4;

  logic signed [SUM_BITS-1:0]   dneg, naneg;
  logic signed [DIFF_BITS-1:0]  dx1neg, dy1neg;
  logic                         dpos, dzero, a_ok, b_ok, cross_next;
  relation_t                    rel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_comb begin
    dpos   = !d[SUM_BITS-1];
    dzero  = (d == '0);
    a_ok   = dpos ? (!na[SUM_BITS-1] && na <= d) : (na <= 0 && na >= d);
    b_ok   = dpos ? (!nb[SUM_BITS-1] && nb <= d) : (nb <= 0 && nb >= d);
    cross_next = !dzero && a_ok && b_ok;
    dneg   = -d;
    naneg  = -na;
    dx1neg = -dx1_3;
    dy1neg = -dy1_3;
    if (dzero) begin
      rel_next = (na == '0 && nb == '0) ? REL_COINCIDENT : REL_PARALLEL;
    end else begin
      rel_next = cross_next ? REL_CROSSING : REL_DISJOINT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1 <= DIFF_BITS'(pair.first_end_x) - DIFF_BITS'(pair.first_start_x);
      dy1 <= DIFF_BITS'(pair.first_end_y) - DIFF_BITS'(pair.first_start_y);
      dx2 <= DIFF_BITS'(pair.second_end_x) - DIFF_BITS'(pair.second_start_x);
      dy2 <= DIFF_BITS'(pair.second_end_y) - DIFF_BITS'(pair.second_start_y);
      ox  <= DIFF_BITS'(pair.first_start_x) - DIFF_BITS'(pair.second_start_x);
      oy  <= DIFF_BITS'(pair.first_start_y) - DIFF_BITS'(pair.second_start_y);
      sx1 <= pair.first_start_x;
      sy1 <= pair.first_start_y;

      pd1 <= PROD_BITS'(dy2) * PROD_BITS'(dx1);
      pd2 <= PROD_BITS'(dx2) * PROD_BITS'(dy1);
      pa1 <= PROD_BITS'(dx2) * PROD_BITS'(oy);
      pa2 <= PROD_BITS'(dy2) * PROD_BITS'(ox);
      pb1 <= PROD_BITS'(dx1) * PROD_BITS'(oy);
      pb2 <= PROD_BITS'(dy1) * PROD_BITS'(ox);
      dx1_2 <= dx1;
      dy1_2 <= dy1;
      sx1_2 <= sx1;
      sy1_2 <= sy1;

      d  <= SUM_BITS'(pd1) - SUM_BITS'(pd2);
      na <= SUM_BITS'(pa1) - SUM_BITS'(pa2);
      nb <= SUM_BITS'(pb1) - SUM_BITS'(pb2);
      dx1_3 <= dx1_2;
      dy1_3 <= dy1_2;
      sx1_3 <= sx1_2;
      sy1_3 <= sy1_2;

      dmag    <= dpos ? d[MAG_BITS-1:0] : dneg[MAG_BITS-1:0];
      namag   <= dpos ? na[MAG_BITS-1:0] : naneg[MAG_BITS-1:0];
      amag[0] <= dx1_3[DIFF_BITS-1] ? dx1neg[COORD_BITS-1:0] : dx1_3[COORD_BITS-1:0];
      amag[1] <= dy1_3[DIFF_BITS-1] ? dy1neg[COORD_BITS-1:0] : dy1_3[COORD_BITS-1:0];
      neg4    <= {dy1_3[DIFF_BITS-1], dx1_3[DIFF_BITS-1]};
      base4   <= {sy1_3, sx1_3};
      cross4  <= cross_next;
      rel4    <= rel_next;

      item.den      <= dmag;
      item.num[0]   <= NUM_BITS'(namag) * NUM_BITS'(amag[0]);
      item.num[1]   <= NUM_BITS'(namag) * NUM_BITS'(amag[1]);
      item.neg      <= neg4;
      item.base     <= base4;
      item.crosses  <= cross4;
      item.relation <= rel4;
    end
  end

  assign out_valid = vld[4];

endmodule

@@ sv/ssi_divide.sv @@
// ----------------------------------------------------------------------------
// ssi_divide
// Restoring division of the scaled numerators by the denominator, one
// quotient bit per register stage, both coordinates side by side.
// ----------------------------------------------------------------------------
module ssi_divide (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  ssi_pkg::ssi_div_t                      item,
  output logic                                   out_valid,
  output ssi_pkg::ssi_div_t                      out_item,
  output logic [1:0][ssi_pkg::MAG_BITS-1:0]      out_rem,
  output logic [1:0][ssi_pkg::COORD_BITS-1:0]    out_quo
);
  import ssi_pkg::*;

  logic [COORD_BITS-1:0]       vld;
  ssi_div_t                    st  [COORD_BITS];
  logic [1:0][MAG_BITS-1:0]    rem [COORD_BITS];
  logic [1:0][COORD_BITS-1:0]  quo [COORD_BITS];

  for (genvar k = 0; k < COORD_BITS; k++) begin : g_step
    ssi_div_t                   st_in;
    logic                       vld_in;
    logic [1:0][MAG_BITS-1:0]   rem_in, rem_next;
    logic [1:0][COORD_BITS-1:0] quo_in, quo_next;
    logic [MAG_BITS:0]          trial [2];
    logic [1:0]                 ge;

    if (k == 0) begin : g_first
      always_comb begin
        st_in     = item;
        vld_in    = in_valid;
        rem_in[0] = item.num[0][NUM_BITS-1:COORD_BITS];
        rem_in[1] = item.num[1][NUM_BITS-1:COORD_BITS];
        quo_in    = '0;
      end
    end else begin : g_rest
      always_comb begin
        st_in  = st[k-1];
        vld_in = vld[k-1];
        rem_in = rem[k-1];
        quo_in = quo[k-1];
      end
    end

    always_comb begin
      quo_next = quo_in;
      for (int l = 0; l < 2; l++) begin
        trial[l] = {rem_in[l], st_in.num[l][COORD_BITS-1-k]};
        ge[l]    = (trial[l] >= {1'b0, st_in.den});
        rem_next[l] = ge[l] ? MAG_BITS'(trial[l] - {1'b0, st_in.den})
                            : trial[l][MAG_BITS-1:0];
        quo_next[l][COORD_BITS-1-k] = ge[l];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k]  <= st_in;
        rem[k] <= rem_next;
        quo[k] <= quo_next;
      end
    end
  end

  assign out_valid = vld[COORD_BITS-1];
  assign out_item  = st[COORD_BITS-1];
  assign out_rem   = rem[COORD_BITS-1];
  assign out_quo   = quo[COORD_BITS-1];

endmodule

@@ sv/segment_segment_intersect_top.sv @@
// Pipeline: 5 front stages, 16 quotient stages and 1 rounding and output
// stage lie between input transfer and result.
// Throughput: one segment pair per cycle; the whole pipeline holds while
// the output register is full and not taken.
// Reset: synchronous, active high; clears all valid bits, drops items in flight.
// ----------------------------------------------------------------------------
// segment_segment_intersect_top
// Two-segment intersection test and crossing point in fixed point.
// ----------------------------------------------------------------------------
module segment_segment_intersect_top (
  input logic       clk,
  input logic       rst,
  ssi_in_if.sink    pair_in,
  ssi_out_if.source result_out
);
  import ssi_pkg::*;

  logic                        en;
  ssi_pair_t                   pair;
  logic                        front_valid, div_valid;
  ssi_div_t                    front_item, div_item;
  logic [1:0][MAG_BITS-1:0]    div_rem;
  logic [1:0][COORD_BITS-1:0]  div_quo;
  logic [1:0][COORD_BITS-1:0]  point;
  logic [COORD_BITS:0]         qr   [2];
  logic [COORD_BITS+1:0]       sum  [2];
  logic                        valid;

  assign en            = !valid || result_out.ready;
  assign pair_in.ready = en;

  always_comb begin
    pair.first_start_x  = pair_in.first_start_x;
    pair.first_start_y  = pair_in.first_start_y;
    pair.first_end_x    = pair_in.first_end_x;
    pair.first_end_y    = pair_in.first_end_y;
    pair.second_start_x = pair_in.second_start_x;
    pair.second_start_y = pair_in.second_start_y;
    pair.second_end_x   = pair_in.second_end_x;
    pair.second_end_y   = pair_in.second_end_y;
  end

  ssi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pair_in.valid),
    .pair      (pair),
    .out_valid (front_valid),
    .item      (front_item)
  );

  ssi_divide u_divide (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .item      (front_item),
    .out_valid (div_valid),
    .out_item  (div_item),
    .out_rem   (div_rem),
    .out_quo   (div_quo)
  );

  // round half away from zero, then offset from the first start point
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      qr[l] = {1'b0, div_quo[l]} +
              (({div_rem[l], 1'b0} >= {1'b0, div_item.den}) ? (COORD_BITS+1)'(1)
                                                             : (COORD_BITS+1)'(0));
      sum[l] = div_item.neg[l]
             ? (COORD_BITS+2)'($signed(div_item.base[l])) - (COORD_BITS+2)'(qr[l])
             : (COORD_BITS+2)'($signed(div_item.base[l])) + (COORD_BITS+2)'(qr[l]);
      point[l] = div_item.crosses ? sum[l][COORD_BITS-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_out.crosses  <= div_item.crosses;
      result_out.relation <= div_item.relation;
      result_out.cross_x  <= point[0];
      result_out.cross_y  <= point[1];
    end
  end

  assign result_out.valid = valid;

endmodule

@@ dv/tb_segment_segment_intersect_top.sv @@
// ----------------------------------------------------------------------------
// tb_segment_segment_intersect_top
// Streams segment pairs through the intersection block under random idling
// and back-pressure, predicts each classification and crossing point with
// exact wide integer arithmetic, and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_segment_segment_intersect_top;
  import ssi_pkg::*;

  localparam int LATENCY   = 22;
  localparam int N_RANDOM  = 1000;
  localparam int MAX_CYCLE = 400000;

  typedef struct packed {
    logic            crosses;
    relation_t       relation;
    logic [15:0]     cross_x;
    logic [15:0]     cross_y;
  } ssi_result_t;

  class intersect_scoreboard;
    ssi_result_t pending[$];
    int          mismatches;

    function automatic logic signed [15:0] offset_point(
        logic signed [15:0] base, logic signed [127:0] na,
        logic signed [127:0] d, logic signed [127:0] delta);
      logic signed [127:0] p;
      logic signed [127:0] mag;
      logic signed [127:0] q;
      logic signed [127:0] r;
      p   = na * delta;
      mag = (p < 0) ? -p : p;
      q   = mag / d;
      r   = mag % d;
      if (2 * r >= d) q = q + 1;
      return (p < 0) ? 16'(base - q) : 16'(base + q);
    endfunction

    function automatic void note_pair(ssi_pair_t s);
      logic signed [127:0] sx1, sy1, sx2, sy2, dx1, dy1, dx2, dy2, ox, oy;
      logic signed [127:0] d, na, nb;
      ssi_result_t e;
      sx1 = s.first_start_x;  sy1 = s.first_start_y;
      sx2 = s.second_start_x; sy2 = s.second_start_y;
      dx1 = 128'(s.first_end_x) - sx1;
      dx1 = $signed(s.first_end_x) - sx1;
      dy1 = $signed(s.first_end_y) - sy1;
      dx2 = $signed(s.second_end_x) - sx2;
      dy2 = $signed(s.second_end_y) - sy2;
      ox  = sx1 - sx2;
      oy  = sy1 - sy2;
      d   = dy2 * dx1 - dx2 * dy1;
      na  = dx2 * oy - dy2 * ox;
      nb  = dx1 * oy - dy1 * ox;
      e   = '0;
      e.relation = REL_DISJOINT;
      if (d == 0) begin
        e.relation = (na == 0 && nb == 0) ? REL_COINCIDENT : REL_PARALLEL;
      end else begin
        if (d < 0) begin
          d  = -d;
          na = -na;
          nb = -nb;
        end
        if (na >= 0 && na <= d && nb >= 0 && nb <= d) begin
          e.crosses  = 1'b1;
          e.relation = REL_CROSSING;
          e.cross_x  = offset_point(s.first_start_x, na, d, dx1);
          e.cross_y  = offset_point(s.first_start_y, na, d, dy1);
        end
      end
      pending.push_back(e);
    endfunction

    function automatic void check_result(ssi_result_t got);
      ssi_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      e = pending.pop_front();
      if (got.crosses !== e.crosses || got.relation !== e.relation ||
          got.cross_x !== e.cross_x || got.cross_y !== e.cross_y) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %b %0d %h %h, got %b %0d %h %h",
                   e.crosses, e.relation, e.cross_x, e.cross_y,
                   got.crosses, got.relation, got.cross_x, got.cross_y);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle = 0;
  bit   hold_off = 0;
  bit   quiet = 0;

  ssi_in_if  pair_in();
  ssi_out_if result_out();
  intersect_scoreboard sb = new();

  segment_segment_intersect_top u_top (
    .clk(clk), .rst(rst), .pair_in(pair_in.sink), .result_out(result_out.source));

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    pair_in.valid = 1'b0;
    {pair_in.first_start_x, pair_in.first_start_y, pair_in.first_end_x,
     pair_in.first_end_y, pair_in.second_start_x, pair_in.second_start_y,
     pair_in.second_end_x, pair_in.second_end_y} = '0;
    result_out.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("tb_segment_segment_intersect_top failed");
      $finish;
    end
    if (!rst && pair_in.valid && pair_in.ready)
      sb.note_pair({pair_in.first_start_x, pair_in.first_start_y, pair_in.first_end_x,
                    pair_in.first_end_y, pair_in.second_start_x, pair_in.second_start_y,
                    pair_in.second_end_x, pair_in.second_end_y});
    if (!rst && result_out.valid && result_out.ready)
      sb.check_result({result_out.crosses, relation_t'(result_out.relation),
                       result_out.cross_x, result_out.cross_y});
  end

  // receiver: random stalls, a quiet stretch, one long hold-off
  always @(negedge clk) begin
    if (rst || hold_off) result_out.ready <= 1'b0;
    else if (quiet)      result_out.ready <= 1'b1;
    else                 result_out.ready <= ($urandom_range(99) >= 14);
  end

  task automatic send_pair(ssi_pair_t s);
    while (!quiet && $urandom_range(99) < 14) @(negedge clk);
    {pair_in.first_start_x, pair_in.first_start_y, pair_in.first_end_x,
     pair_in.first_end_y, pair_in.second_start_x, pair_in.second_start_y,
     pair_in.second_end_x, pair_in.second_end_y} = s;
    pair_in.valid = 1'b1;
    @(posedge clk);
    while (!pair_in.ready) @(posedge clk);
    @(negedge clk);
    pair_in.valid = 1'b0;
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(5))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'($urandom_range(8)) - 16'd4;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic ssi_pair_t random_pair();
    ssi_pair_t s;
    logic [15:0] t;
    s = {pick_coord(), pick_coord(), pick_coord(), pick_coord(),
         pick_coord(), pick_coord(), pick_coord(), pick_coord()};
    case ($urandom_range(9))
      // cross through a shared point
      0, 1, 2: begin
        s.second_start_x = s.first_start_x + (s.first_end_x - s.first_start_x) / 2 - 16'sd40;
        s.second_end_x   = s.second_start_x + 16'sd80;
        s.second_start_y = s.first_start_y + (s.first_end_y - s.first_start_y) / 2 + 16'sd33;
        s.second_end_y   = s.second_start_y - 16'sd66;
      end
      // parallel or collinear
      3: begin
        t = 16'($urandom_range(3));
        s.second_end_x = s.second_start_x + (s.first_end_x - s.first_start_x);
        s.second_end_y = s.second_start_y + (s.first_end_y - s.first_start_y);
        if (t == 0) begin
          s.second_start_x = s.first_start_x;
          s.second_start_y = s.first_start_y;
          s.second_end_x   = s.first_end_x;
          s.second_end_y   = s.first_end_y;
        end
      end
      // zero-length segment
      4: begin
        s.first_end_x = s.first_start_x;
        s.first_end_y = s.first_start_y;
      end
      // small coordinates, frequent exact endpoint touches
      5, 6: s = {16'($urandom_range(6)), 16'($urandom_range(6)), 16'($urandom_range(6)),
                 16'($urandom_range(6)), 16'($urandom_range(6)), 16'($urandom_range(6)),
                 16'($urandom_range(6)), 16'($urandom_range(6))};
      default: ;
    endcase
    return s;
  endfunction

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    ssi_pair_t directed[$];
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed.push_back({16'sd0, 16'sd0, 16'sd160, 16'sd160, 16'sd0, 16'sd160, 16'sd160, 16'sd0});
    directed.push_back({16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd0, 16'sd32, 16'sd16, 16'sd32});
    directed.push_back({16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd32, 16'sd0, 16'sd48, 16'sd0});
    directed.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd5, 16'sd5, 16'sd5, 16'sd5});
    directed.push_back({16'sd0, 16'sd0, 16'sd16, 16'sd16, 16'sd100, 16'sd0, 16'sd100, 16'sd16});
    directed.push_back({16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd16, -16'sd8, 16'sd16, 16'sd8});
    directed.push_back({16'sd0, 16'sd0, 16'sd3, 16'sd0, 16'sd1, -16'sd1, 16'sd1, 16'sd1});
    directed.push_back({16'sd0, 16'sd0, -16'sd3, 16'sd0, -16'sd1, -16'sd1, -16'sd1, 16'sd1});
    directed.push_back({16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                        16'h8000, 16'h7fff, 16'h7fff, 16'h8000});
    directed.push_back({16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                        16'h8000, 16'h8000, 16'h7fff, 16'h7ffe});
    directed.push_back({16'hffff, 16'hffff, 16'hffff, 16'hffff,
                        16'hffff, 16'hffff, 16'hffff, 16'hffff});
    directed.push_back({16'h5555, 16'haaaa, 16'haaaa, 16'h5555,
                        16'haaaa, 16'haaaa, 16'h5555, 16'h5555});
    foreach (directed[i]) send_pair(directed[i]);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 200) begin
        drain();
        quiet = 1;
      end
      if (n == 350) quiet = 0;
      if (n == 500) fork
        begin
          hold_off = 1;
          repeat (80) @(posedge clk);
          @(negedge clk);
          hold_off = 0;
        end
      join_none
      send_pair(random_pair());
    end
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("tb_segment_segment_intersect_top passed");
    else
      $display("tb_segment_segment_intersect_top failed");
    $finish;
  end

endmodule

@@ segment_segment_intersect_top.f @@
sv/ssi_pkg.sv
sv/ssi_in_if.sv
sv/ssi_out_if.sv
sv/ssi_front.sv
sv/ssi_divide.sv
sv/segment_segment_intersect_top.sv
dv/tb_segment_segment_intersect_top.sv
